// ----- hw/rtl/pts_pkg.sv -----
// Shared constants and helpers for the particle thrust step block.
`default_nettype none
package pts_pkg;
    localparam int unsigned FracBitsDef = 16;
    localparam int unsigned DtBits      = 16;
    localparam int unsigned ThrustGain  = 1000;
    localparam int unsigned FrictionQ16 = 64225;
    localparam logic [15:0] StepTimeRst = 16'd1092;
    localparam logic [23:0] RadiusRst   = 24'd65536;
    localparam logic [30:0] BoxHalfRst  = 31'd13107200;

    localparam logic [1:0] OpThrust = 2'd0;
    localparam logic [1:0] OpLoadPos = 2'd1;
    localparam logic [1:0] OpLoadVel = 2'd2;

    localparam logic [1:0] RegStepTime = 2'd0;
    localparam logic [1:0] RegRadius   = 2'd1;
    localparam logic [1:0] RegBoxHalf  = 2'd2;

    // Saturate a 66-bit signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        begin
            hi = 66'sd2147483647;
            lo = -66'sd2147483648;
            if (x > hi) sat32 = 32'sh7fffffff;
            else if (x < lo) sat32 = 32'sh80000000;
            else sat32 = x[31:0];
        end
    endfunction

    // Divide by 2^16, round to nearest, ties up (floor of x + half).
    function automatic logic signed [65:0] rnd16(input logic signed [65:0] x);
        logic signed [65:0] t;
        begin
            t = x + 66'sd32768;
            rnd16 = t >>> DtBits;
        end
    endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/pts_divsqrt.sv -----
// Bit-serial unit: 64-bit integer square root, then restoring divides.
`default_nettype none
module pts_divsqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_sqrt_start,
    input  wire logic [63:0] i_radicand,
    input  wire logic        i_div_start,
    input  wire logic [63:0] i_dividend,
    output logic             o_busy,
    output logic [63:0]      o_result
);
    import pts_pkg::*;

    localparam logic [1:0] SIdle = 2'd0;
    localparam logic [1:0] SSqrt = 2'd1;
    localparam logic [1:0] SDiv  = 2'd2;

    logic [1:0]  r_state, n_state;
    logic [5:0]  r_cnt, n_cnt;
    logic [63:0] r_acc, n_acc;   // remainder
    logic [63:0] r_q, n_q;       // root or quotient
    logic [63:0] r_n, n_n;       // shifting operand
    logic [63:0] r_div, n_div;   // latched root used as divisor
    logic [65:0] w_trial;
    logic [64:0] w_rem;

    // One root bit or one quotient bit per cycle
    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_acc = r_acc; n_q = r_q;
        n_n = r_n; n_div = r_div;
        w_trial = '0; w_rem = '0;
        case (r_state)
            SIdle: begin
                if (i_sqrt_start) begin
                    n_state = SSqrt; n_cnt = 6'd31; n_acc = '0; n_q = '0;
                    n_n = i_radicand;
                end else if (i_div_start) begin
                    n_state = SDiv; n_cnt = 6'd63; n_acc = '0; n_q = '0;
                    n_n = i_dividend;
                end
            end
            SSqrt: begin
                w_trial = {r_acc, r_n[63:62]} - {r_q, 2'b01};
                if (!w_trial[65]) begin
                    n_acc = w_trial[63:0]; n_q = {r_q[62:0], 1'b1};
                end else begin
                    n_acc = {r_acc[61:0], r_n[63:62]}; n_q = {r_q[62:0], 1'b0};
                end
                n_n = {r_n[61:0], 2'b00};
                n_cnt = r_cnt - 6'd1;
                // keep the root as divisor for all following divides
                if (r_cnt == '0) begin
                    n_state = SIdle;
                    n_div = n_q;
                end
            end
            SDiv: begin
                w_rem = {r_acc, r_n[63]} - {1'b0, r_div};
                if (!w_rem[64]) begin
                    n_acc = w_rem[63:0]; n_q = {r_q[62:0], 1'b1};
                end else begin
                    n_acc = {r_acc[62:0], r_n[63]}; n_q = {r_q[62:0], 1'b0};
                end
                n_n = {r_n[62:0], 1'b0};
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == '0) n_state = SIdle;
            end
            default: n_state = SIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SIdle;
        end else begin
            r_state <= n_state;
        end
        r_cnt <= n_cnt; r_acc <= n_acc; r_q <= n_q; r_n <= n_n; r_div <= n_div;
    end

    assign o_busy = (r_state != SIdle);
    assign o_result = r_q;

`ifndef SYNTHESIS
    a_state_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != 2'd3) else $error("bad unit state");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sqrt_start && !o_busy) |=> o_busy) else $error("start not taken");
    a_sqrt_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SSqrt && r_cnt == '0) |=> !o_busy) else $error("sqrt overrun");
`endif
endmodule
`default_nettype wire

// ----- hw/rtl/particle_thrust_step_with_walls.sv -----
// Top level: particle state, sequencer, shared multiplier and wall check.
//
// Holds one particle's position and velocity in signed fixed point. A load
// op puts its result out in the cycle after it is taken. A thrust step
// forms the sum of squares, takes the square root, runs 3 bit-serial
// divides for the normalization (skipped for a zero vector), then takes
// 12 steps through one shared 32x27 multiplier, 3 position and 3 wall
// steps. The block takes no new beat until the result beat has been taken.
`default_nettype none
module particle_thrust_step_with_walls #(
    parameter int unsigned FRAC_BITS = pts_pkg::FracBitsDef
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [1:0]         i_op,
    input  wire logic signed [31:0] i_vec_x,
    input  wire logic signed [31:0] i_vec_y,
    input  wire logic signed [31:0] i_vec_z,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [31:0]      o_pos_x,
    output logic signed [31:0]      o_pos_y,
    output logic signed [31:0]      o_pos_z,
    output logic signed [31:0]      o_vel_x,
    output logic signed [31:0]      o_vel_y,
    output logic signed [31:0]      o_vel_z,
    output logic [2:0]              o_wall_hits
);
    import pts_pkg::*;

    localparam logic [3:0] SIdle = 4'd0;
    localparam logic [3:0] SSqS  = 4'd1;
    localparam logic [3:0] SSqW  = 4'd2;
    localparam logic [3:0] SDivS = 4'd3;
    localparam logic [3:0] SDivW = 4'd4;
    localparam logic [3:0] SThr  = 4'd5;
    localparam logic [3:0] SAdd  = 4'd6;
    localparam logic [3:0] SFri  = 4'd7;
    localparam logic [3:0] SPos  = 4'd8;
    localparam logic [3:0] SWall = 4'd9;
    localparam logic [3:0] SOut  = 4'd10;
    localparam logic [3:0] SSum  = 4'd11;
    localparam logic [3:0] SMul  = 4'd12;

    logic [15:0] r_dt;
    logic [23:0] r_rad;
    logic [30:0] r_box;
    logic signed [31:0] r_pos [3];
    logic signed [31:0] r_vel [3];
    logic signed [31:0] r_vec [3];
    logic signed [63:0] r_unit [3];
    logic [63:0] r_sum;
    logic [3:0]  r_state;
    logic [1:0]  r_ax;
    logic [2:0]  r_hits;
    logic signed [65:0] r_prod;
    logic        r_zero;

    logic        w_busy, w_sq_go, w_dv_go;
    logic [63:0] w_res, w_dvd, w_sq;
    logic signed [31:0] w_a;
    logic signed [26:0] w_b;
    logic [25:0] w_gdt;
    logic signed [58:0] w_prod;
    logic signed [65:0] w_mul;
    logic [31:0] w_absv;
    logic signed [63:0] w_q;
    logic signed [65:0] w_p, w_r, w_b66, w_hi, w_lo;

    assign w_absv = r_vec[r_ax][31] ? (~r_vec[r_ax] + 32'd1) : r_vec[r_ax];
    assign w_sq = 64'(w_absv) * 64'(w_absv);
    assign w_dvd = 64'(w_absv) << FRAC_BITS;
    assign w_sq_go = (r_state == SSqS);
    assign w_dv_go = (r_state == SDivS);
    assign w_q = r_vec[r_ax][31] ? -$signed(w_res) : $signed(w_res);

    pts_divsqrt u_unit (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_sqrt_start(w_sq_go), .i_radicand(r_sum),
        .i_div_start(w_dv_go), .i_dividend(w_dvd),
        .o_busy(w_busy), .o_result(w_res)
    );

    // thrust gain times step time, below 2^26
    assign w_gdt = 26'(ThrustGain) * 26'(r_dt);

    // Shared multiplier operand select
    always_comb begin
        w_a = '0; w_b = '0;
        case (r_state)
            SThr:  begin w_a = r_unit[r_ax][31:0]; w_b = $signed({1'b0, w_gdt}); end
            SFri:  begin w_a = r_vel[r_ax]; w_b = 27'(FrictionQ16); end
            SPos:  begin w_a = r_vel[r_ax]; w_b = $signed({11'b0, r_dt}); end
            default: ;
        endcase
    end
    assign w_prod = w_a * w_b;
    assign w_mul  = 66'(w_prod);

    assign w_p   = 66'(r_pos[r_ax]);
    assign w_r   = 66'(r_rad);
    assign w_b66 = 66'(r_box);
    assign w_hi  = w_b66 - w_r;
    assign w_lo  = w_r - w_b66;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SIdle;
            r_dt <= StepTimeRst; r_rad <= RadiusRst; r_box <= BoxHalfRst;
            for (int i = 0; i < 3; i++) begin
                r_pos[i] <= '0; r_vel[i] <= '0;
            end
            r_hits <= '0;
            r_ax <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    RegStepTime: r_dt <= i_cfg_data[15:0];
                    RegRadius:   r_rad <= i_cfg_data[23:0];
                    RegBoxHalf:  r_box <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
            case (r_state)
                SIdle: if (i_valid) begin
                    r_vec[0] <= i_vec_x; r_vec[1] <= i_vec_y; r_vec[2] <= i_vec_z;
                    r_hits <= '0; r_ax <= '0; r_sum <= '0;
                    case (i_op)
                        OpThrust: r_state <= SSum;
                        OpLoadPos: begin
                            r_pos[0] <= i_vec_x; r_pos[1] <= i_vec_y;
                            r_pos[2] <= i_vec_z; r_state <= SOut;
                        end
                        OpLoadVel: begin
                            r_vel[0] <= i_vec_x; r_vel[1] <= i_vec_y;
                            r_vel[2] <= i_vec_z; r_state <= SOut;
                        end
                        default: r_state <= SOut;
                    endcase
                end
                // Sum of squares, one axis per cycle
                SSum: begin
                    r_sum <= r_sum + w_sq;
                    if (r_ax == 2'd2) begin r_ax <= '0; r_state <= SSqS; end
                    else r_ax <= r_ax + 2'd1;
                end
                SSqS: r_state <= SSqW;
                SSqW: if (!w_busy) begin
                    r_zero <= (w_res == '0);
                    if (w_res == '0) begin
                        for (int i = 0; i < 3; i++) r_unit[i] <= '0;
                        r_state <= SThr;
                    end else r_state <= SDivS;
                end
                SDivS: r_state <= SDivW;
                SDivW: if (!w_busy) begin
                    r_unit[r_ax] <= w_q;
                    if (r_ax == 2'd2) begin r_ax <= '0; r_state <= SThr; end
                    else begin r_ax <= r_ax + 2'd1; r_state <= SDivS; end
                end
                SThr: begin r_prod <= w_mul; r_state <= SAdd; end
                SAdd: begin
                    r_vel[r_ax] <= sat32(66'(r_vel[r_ax]) + rnd16(r_prod));
                    r_state <= SFri;
                end
                SFri: begin r_prod <= w_mul; r_state <= SMul; end
                SMul: begin
                    r_vel[r_ax] <= sat32(rnd16(r_prod));
                    if (r_ax == 2'd2) r_ax <= '0; else r_ax <= r_ax + 2'd1;
                    r_state <= (r_ax == 2'd2) ? SPos : SThr;
                end
                SPos: begin
                    r_pos[r_ax] <= sat32(w_p + rnd16(w_mul));
                    if (r_ax == 2'd2) begin r_ax <= '0; r_state <= SWall; end
                    else r_ax <= r_ax + 2'd1;
                end
                // Wall clamp and reflect, one axis per cycle
                SWall: begin
                    if ((w_p + w_r >= w_b66) || (w_p - w_r <= -w_b66)) begin
                        r_pos[r_ax] <= (w_p + w_r >= w_b66) ? sat32(w_hi) : sat32(w_lo);
                        r_vel[r_ax] <= sat32(-66'(r_vel[r_ax]));
                        r_hits[r_ax] <= 1'b1;
                    end
                    if (r_ax == 2'd2) begin r_ax <= '0; r_state <= SOut; end
                    else r_ax <= r_ax + 2'd1;
                end
                SOut: if (i_ready) r_state <= SIdle;
                default: r_state <= SIdle;
            endcase
        end
    end

    assign o_ready = (r_state == SIdle);
    assign o_cfg_ready = 1'b1;
    assign o_valid = (r_state == SOut);
    assign o_pos_x = r_pos[0]; assign o_pos_y = r_pos[1]; assign o_pos_z = r_pos[2];
    assign o_vel_x = r_vel[0]; assign o_vel_y = r_vel[1]; assign o_vel_z = r_vel[2];
    assign o_wall_hits = r_hits;

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("ready during result");
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_pos_x) && $stable(o_vel_x)))
        else $error("result changed while stalled");
    a_ax_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ax != 2'd3) else $error("axis index out of range");
    a_zero_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SThr && r_zero) |-> r_unit[r_ax] == '0) else $error("zero vector");
`endif
endmodule
`default_nettype wire
